// ----- rtl/mbd_pkg.sv -----
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int COMP_W     = 8;
    localparam int SUM_W      = COMP_W + 1;
    localparam int NCOMP      = 4;
    localparam int PAIR_W     = NCOMP * SUM_W;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int RESET_DIM  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LENGTH = 2'd0,
        REG_LINE_COUNT  = 2'd1
    } cfg_idx_t;

    typedef logic [NCOMP-1:0][COMP_W-1:0] pixel_t;
    typedef logic [NCOMP-1:0][SUM_W-1:0]  pair_t;

    // what a pixel transaction asks of the filter stage
    typedef struct packed {
        logic wr;
        logic emit;
        logic last;
    } item_ctl_t;

endpackage

// ----- rtl/mbd_ram.sv -----
`timescale 1ns / 1ps

module mbd_ram #(
    parameter int WIDTH  = 36,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mbd_cfg.sv -----
`timescale 1ns / 1ps

module mbd_cfg #(
    parameter int MAX_LINE_LENGTH = 1024,
    parameter int MAX_LINE_COUNT  = 1024,
    parameter int LEN_W           = $clog2(MAX_LINE_LENGTH + 1),
    parameter int CNT_W           = $clog2(MAX_LINE_COUNT + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [LEN_W-1:0]               line_length,
    output logic [CNT_W-1:0]               line_count,
    output logic                           restart
);

    localparam int LEN_RST = (MAX_LINE_LENGTH < mbd_pkg::RESET_DIM) ?
                             MAX_LINE_LENGTH : mbd_pkg::RESET_DIM;
    localparam int CNT_RST = (MAX_LINE_COUNT < mbd_pkg::RESET_DIM) ?
                             MAX_LINE_COUNT : mbd_pkg::RESET_DIM;

    logic [LEN_W-1:0] line_length_reg, line_length_next;
    logic [CNT_W-1:0] line_count_reg, line_count_next;
    logic [31:0]      data_ext;
    logic [31:0]      len_clamped;
    logic [31:0]      cnt_clamped;

    assign data_ext = 32'(cfg_data);

    // zero acts as one, large values saturate
    always_comb begin
        if (data_ext == 32'd0) begin
            len_clamped = 32'd1;
            cnt_clamped = 32'd1;
        end else begin
            len_clamped = (data_ext > 32'(MAX_LINE_LENGTH)) ? 32'(MAX_LINE_LENGTH) : data_ext;
            cnt_clamped = (data_ext > 32'(MAX_LINE_COUNT)) ? 32'(MAX_LINE_COUNT) : data_ext;
        end
    end

    always_comb begin
        line_length_next = line_length_reg;
        line_count_next  = line_count_reg;
        restart          = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                mbd_pkg::REG_LINE_LENGTH: begin
                    line_length_next = LEN_W'(len_clamped);
                    restart          = 1'b1;
                end
                mbd_pkg::REG_LINE_COUNT: begin
                    line_count_next = CNT_W'(cnt_clamped);
                    restart         = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= LEN_W'(LEN_RST);
            line_count_reg  <= CNT_W'(CNT_RST);
        end else begin
            line_length_reg <= line_length_next;
            line_count_reg  <= line_count_next;
        end
    end

    assign line_length = line_length_reg;
    assign line_count  = line_count_reg;

endmodule

// ----- rtl/mbd_ctrl.sv -----
`timescale 1ns / 1ps

module mbd_ctrl #(
    parameter int MAX_LINE_LENGTH = 1024,
    parameter int MAX_LINE_COUNT  = 1024,
    parameter int LEN_W           = $clog2(MAX_LINE_LENGTH + 1),
    parameter int CNT_W           = $clog2(MAX_LINE_COUNT + 1),
    parameter int ADDR_W          = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  restart,
    input  logic [LEN_W-1:0]      line_length,
    input  logic [CNT_W-1:0]      line_count,
    input  logic                  accept,
    input  mbd_pkg::pixel_t       pixel,
    output mbd_pkg::item_ctl_t    ctl,
    output mbd_pkg::pair_t        pair,
    output logic [ADDR_W-1:0]     slot
);

    localparam int COL_W  = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH) : 1;
    localparam int LINE_W = (MAX_LINE_COUNT > 1) ? $clog2(MAX_LINE_COUNT) : 1;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    mbd_pkg::pixel_t   held_reg, held_next;
    logic [LEN_W-1:0]  col_ext, col_inc, even_len;
    logic [CNT_W-1:0]  line_ext, line_inc, even_cnt;
    logic              active;

    assign col_ext  = LEN_W'(col_reg);
    assign line_ext = CNT_W'(line_reg);
    assign col_inc  = col_ext + LEN_W'(1);
    assign line_inc = line_ext + CNT_W'(1);
    assign even_len = {line_length[LEN_W-1:1], 1'b0};
    assign even_cnt = {line_count[CNT_W-1:1], 1'b0};

    assign active   = col_reg[0] && (col_ext < even_len) && (line_ext < even_cnt);
    assign ctl.wr   = active && !line_reg[0];
    assign ctl.emit = active && line_reg[0];
    assign ctl.last = (line_ext == even_cnt - CNT_W'(1)) && (col_ext == even_len - LEN_W'(1));
    assign slot     = ADDR_W'(col_reg >> 1);

    // horizontal pair sums
    always_comb begin
        for (int k = 0; k < mbd_pkg::NCOMP; k++) begin
            pair[k] = {1'b0, held_reg[k]} + {1'b0, pixel[k]};
        end
    end

    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        held_next = held_reg;
        if (restart) begin
            col_next  = '0;
            line_next = '0;
        end else if (accept) begin
            if (!col_reg[0]) begin
                held_next = pixel;
            end
            if (col_inc >= line_length) begin
                col_next  = '0;
                line_next = (line_inc >= line_count) ? '0 : LINE_W'(line_inc);
            end else begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= '0;
            held_reg <= '0;
        end else begin
            col_reg  <= col_next;
            line_reg <= line_next;
            held_reg <= held_next;
        end
    end

    a_col_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        col_ext < line_length)
        else $error("column position beyond line length");

    a_line_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        line_ext < line_count)
        else $error("line position beyond line count");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (col_reg == '0) && (line_reg == '0))
        else $error("frame position kept across a register write");

endmodule

// ----- rtl/mbd_filter.sv -----
`timescale 1ns / 1ps

module mbd_filter #(
    parameter int ADDR_W = 9
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  mbd_pkg::item_ctl_t          ctl,
    input  mbd_pkg::pair_t              pair,
    input  logic [ADDR_W-1:0]           slot,
    output logic                        in_ready,
    output logic                        ram_we,
    output logic [ADDR_W-1:0]           ram_waddr,
    output mbd_pkg::pair_t              ram_wdata,
    input  mbd_pkg::pair_t              ram_rdata,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mbd_pkg::pixel_t             m_pixel,
    output logic                        m_last
);

    logic               s1_valid_reg, s1_valid_next;
    mbd_pkg::item_ctl_t s1_ctl_reg;
    mbd_pkg::pair_t     s1_pair_reg;
    logic [ADDR_W-1:0]  s1_slot_reg;
    logic               out_valid_reg, out_valid_next;
    mbd_pkg::pixel_t    out_pixel_reg, out_pixel_next;
    logic               out_last_reg, out_last_next;
    logic               s1_go;
    logic [mbd_pkg::SUM_W:0] total [mbd_pkg::NCOMP];

    assign s1_go    = s1_valid_reg && (!s1_ctl_reg.emit || !out_valid_reg || m_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    assign ram_we    = s1_go && s1_ctl_reg.wr;
    assign ram_waddr = s1_slot_reg;
    assign ram_wdata = s1_pair_reg;

    // vertical sum and divide by four
    always_comb begin
        for (int k = 0; k < mbd_pkg::NCOMP; k++) begin
            total[k] = {1'b0, ram_rdata[k]} + {1'b0, s1_pair_reg[k]};
        end
    end

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_pixel_next = out_pixel_reg;
        out_last_next  = out_last_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end
        if (s1_go && s1_ctl_reg.emit) begin
            out_valid_next = 1'b1;
            out_last_next  = s1_ctl_reg.last;
            for (int k = 0; k < mbd_pkg::NCOMP; k++) begin
                out_pixel_next[k] = total[k][mbd_pkg::SUM_W:2];
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg  <= ctl;
            s1_pair_reg <= pair;
            s1_slot_reg <= slot;
        end
        out_pixel_reg <= out_pixel_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid = out_valid_reg;
    assign m_pixel = out_pixel_reg;
    assign m_last  = out_last_reg;

    a_write_or_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> !(s1_ctl_reg.wr && s1_ctl_reg.emit))
        else $error("stage item both writes and emits");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_pair_reg)
            && $stable(s1_ctl_reg))
        else $error("stalled stage item changed");

    a_emit_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(out_valid_reg) && out_valid_reg |-> $past(s1_go && s1_ctl_reg.emit))
        else $error("result appeared without an emitting stage item");

endmodule

// ----- rtl/mipmap_box_downsample_top.sv -----
`timescale 1ns / 1ps
// channel   | valid / ready          | payload
// ----------+------------------------+------------------------------------
// s_ pixel  | s_valid / s_ready      | s_comp0..s_comp3
// m_ result | m_valid / m_ready      | m_out0..m_out3, m_frame_end
// cfg write | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one pixel transaction per cycle while results are not stalled; the pixel that completes
// a 2x2 block passes through the stage reg (with line buffer read), then the output reg
// the line buffer has one write and one read port: read for every pixel, written once per pair on even lines
// reset clears the frame position and restores both dimensions to 64 (or to the maximum if smaller)
// a stalled result holds the stage behind it when that stage item emits; pixels keep flowing otherwise

module mipmap_box_downsample_top #(
    parameter int MAX_LINE_LENGTH = 1024,
    parameter int MAX_LINE_COUNT  = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mbd_pkg::COMP_W-1:0]     s_comp0,
    input  logic [mbd_pkg::COMP_W-1:0]     s_comp1,
    input  logic [mbd_pkg::COMP_W-1:0]     s_comp2,
    input  logic [mbd_pkg::COMP_W-1:0]     s_comp3,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mbd_pkg::COMP_W-1:0]     m_out0,
    output logic [mbd_pkg::COMP_W-1:0]     m_out1,
    output logic [mbd_pkg::COMP_W-1:0]     m_out2,
    output logic [mbd_pkg::COMP_W-1:0]     m_out3,
    output logic                           m_frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LEN_W  = $clog2(MAX_LINE_LENGTH + 1);
    localparam int CNT_W  = $clog2(MAX_LINE_COUNT + 1);
    localparam int DEPTH  = MAX_LINE_LENGTH / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LEN_W-1:0]   line_length;
    logic [CNT_W-1:0]   line_count;
    logic               restart;
    logic               accept;
    mbd_pkg::pixel_t    pixel;
    mbd_pkg::item_ctl_t ctl;
    mbd_pkg::pair_t     pair;
    logic [ADDR_W-1:0]  slot;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    mbd_pkg::pair_t     ram_wdata;
    mbd_pkg::pair_t     ram_rdata;
    mbd_pkg::pixel_t    m_pixel;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign pixel     = {s_comp3, s_comp2, s_comp1, s_comp0};

    mbd_cfg #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
        .MAX_LINE_COUNT  (MAX_LINE_COUNT),
        .LEN_W           (LEN_W),
        .CNT_W           (CNT_W)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .line_length (line_length),
        .line_count  (line_count),
        .restart     (restart)
    );

    mbd_ctrl #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
        .MAX_LINE_COUNT  (MAX_LINE_COUNT),
        .LEN_W           (LEN_W),
        .CNT_W           (CNT_W),
        .ADDR_W          (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (restart),
        .line_length (line_length),
        .line_count  (line_count),
        .accept      (accept),
        .pixel       (pixel),
        .ctl         (ctl),
        .pair        (pair),
        .slot        (slot)
    );

    mbd_ram #(
        .WIDTH  (mbd_pkg::PAIR_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    mbd_filter #(
        .ADDR_W (ADDR_W)
    ) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .ctl       (ctl),
        .pair      (pair),
        .slot      (slot),
        .in_ready  (s_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pixel   (m_pixel),
        .m_last    (m_frame_end)
    );

    assign m_out0 = m_pixel[0];
    assign m_out1 = m_pixel[1];
    assign m_out2 = m_pixel[2];
    assign m_out3 = m_pixel[3];

endmodule

// ----- bench/box_avg_checker.sv -----
`timescale 1ns / 1ps

module box_avg_checker #(
    parameter int MAX_LINE_LENGTH = 1024,
    parameter int MAX_LINE_COUNT  = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [mbd_pkg::COMP_W-1:0]     s_comp0,
    input  logic [mbd_pkg::COMP_W-1:0]     s_comp1,
    input  logic [mbd_pkg::COMP_W-1:0]     s_comp2,
    input  logic [mbd_pkg::COMP_W-1:0]     s_comp3,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [mbd_pkg::COMP_W-1:0]     m_out0,
    input  logic [mbd_pkg::COMP_W-1:0]     m_out1,
    input  logic [mbd_pkg::COMP_W-1:0]     m_out2,
    input  logic [mbd_pkg::COMP_W-1:0]     m_out3,
    input  logic                           m_frame_end,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);

    localparam int CFG_DATA_W = mbd_pkg::CFG_DATA_W;
    localparam int SUM_W      = mbd_pkg::SUM_W;
    localparam int NCOMP      = mbd_pkg::NCOMP;
    localparam int SLOTS      = MAX_LINE_LENGTH / 2;
    localparam int COL_W      = $clog2(MAX_LINE_LENGTH);
    localparam int LINE_W     = $clog2(MAX_LINE_COUNT);
    localparam int REPORTS    = 10;

    typedef struct packed {
        mbd_pkg::pixel_t avg;
        logic            frame_end;
    } block_avg_t;

    logic [CFG_DATA_W-1:0] line_len;
    logic [CFG_DATA_W-1:0] line_cnt;
    logic [COL_W-1:0]      col_pos;
    logic [LINE_W-1:0]     line_pos;
    mbd_pkg::pixel_t       held;
    mbd_pkg::pair_t        pair_mem [SLOTS];
    block_avg_t            avg_q [$];
    int                    mismatches = 0;

    function automatic logic [CFG_DATA_W-1:0] clamp_dim(
        input logic [CFG_DATA_W-1:0] v,
        input int                    hi
    );
        if (v == '0)
            return CFG_DATA_W'(1);
        if (int'(v) > hi)
            return CFG_DATA_W'(hi);
        return v;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORTS)
            $display("%s", msg);
    endtask

    task automatic predict_pixel(input mbd_pkg::pixel_t cur);
        logic [CFG_DATA_W-1:0] even_len;
        logic [CFG_DATA_W-1:0] even_cnt;
        logic [CFG_DATA_W-1:0] col_ext;
        logic [CFG_DATA_W-1:0] line_ext;
        mbd_pkg::pair_t        sums;
        logic [SUM_W:0]        total;
        block_avg_t            e;
        int                    slot;
        even_len = {line_len[CFG_DATA_W-1:1], 1'b0};
        even_cnt = {line_cnt[CFG_DATA_W-1:1], 1'b0};
        col_ext  = CFG_DATA_W'(col_pos);
        line_ext = CFG_DATA_W'(line_pos);
        if (!col_pos[0]) begin
            held = cur;
        end else if (col_ext < even_len && line_ext < even_cnt) begin
            slot = int'(col_pos >> 1) % SLOTS;
            for (int k = 0; k < NCOMP; k++)
                sums[k] = {1'b0, held[k]} + {1'b0, cur[k]};
            if (!line_pos[0]) begin
                pair_mem[slot] = sums;
            end else begin
                for (int k = 0; k < NCOMP; k++) begin
                    total    = {1'b0, pair_mem[slot][k]} + {1'b0, sums[k]};
                    e.avg[k] = total[SUM_W:2];
                end
                e.frame_end = (line_ext == even_cnt - CFG_DATA_W'(1)) &&
                              (col_ext == even_len - CFG_DATA_W'(1));
                avg_q.push_back(e);
            end
        end
        if (col_ext + CFG_DATA_W'(1) >= line_len) begin
            col_pos  = '0;
            line_pos = (line_ext + CFG_DATA_W'(1) >= line_cnt) ? '0 : line_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic check_result(input mbd_pkg::pixel_t got, input logic got_end);
        block_avg_t e;
        logic       bad;
        if (avg_q.size() == 0) begin
            note_failure($sformatf("unexpected result %0d %0d %0d %0d end %0b",
                                   got[0], got[1], got[2], got[3], got_end));
        end else begin
            e   = avg_q.pop_front();
            bad = (got_end != e.frame_end);
            for (int k = 0; k < NCOMP; k++)
                if (got[k] != e.avg[k])
                    bad = 1'b1;
            if (bad)
                note_failure($sformatf(
                    {"result mismatch: expected %0d %0d %0d %0d end %0b, ",
                     "got %0d %0d %0d %0d end %0b"},
                    e.avg[0], e.avg[1], e.avg[2], e.avg[3], e.frame_end,
                    got[0], got[1], got[2], got[3], got_end));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_len = CFG_DATA_W'(mbd_pkg::RESET_DIM);
            line_cnt = CFG_DATA_W'(mbd_pkg::RESET_DIM);
            col_pos  = '0;
            line_pos = '0;
            held     = '0;
            avg_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mbd_pkg::REG_LINE_LENGTH: begin
                        line_len = clamp_dim(cfg_data, MAX_LINE_LENGTH);
                        col_pos  = '0;
                        line_pos = '0;
                    end
                    mbd_pkg::REG_LINE_COUNT: begin
                        line_cnt = clamp_dim(cfg_data, MAX_LINE_COUNT);
                        col_pos  = '0;
                        line_pos = '0;
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready)
                check_result({m_out3, m_out2, m_out1, m_out0}, m_frame_end);
            if (s_valid && s_ready)
                predict_pixel({s_comp3, s_comp2, s_comp1, s_comp0});
        end
        pending    <= avg_q.size();
        fail_count <= mismatches;
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int COMP_W          = mbd_pkg::COMP_W;
    localparam int CFG_IDX_W       = mbd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = mbd_pkg::CFG_DATA_W;
    localparam int MAX_LINE_LENGTH = 1024;
    localparam int MAX_LINE_COUNT  = 1024;
    localparam int SETTLE          = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_ITEMS    = 130;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [COMP_W-1:0]     s_comp0;
    logic [COMP_W-1:0]     s_comp1;
    logic [COMP_W-1:0]     s_comp2;
    logic [COMP_W-1:0]     s_comp3;
    logic                  m_valid;
    logic                  m_ready;
    logic [COMP_W-1:0]     m_out0;
    logic [COMP_W-1:0]     m_out1;
    logic [COMP_W-1:0]     m_out2;
    logic [COMP_W-1:0]     m_out3;
    logic                  m_frame_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    src_idle_pct;
    int                    snk_idle_pct;
    int                    quiet;

    mipmap_box_downsample_top #(
        .MAX_LINE_LENGTH(MAX_LINE_LENGTH),
        .MAX_LINE_COUNT (MAX_LINE_COUNT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_comp0    (s_comp0),
        .s_comp1    (s_comp1),
        .s_comp2    (s_comp2),
        .s_comp3    (s_comp3),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out0     (m_out0),
        .m_out1     (m_out1),
        .m_out2     (m_out2),
        .m_out3     (m_out3),
        .m_frame_end(m_frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    box_avg_checker #(
        .MAX_LINE_LENGTH(MAX_LINE_LENGTH),
        .MAX_LINE_COUNT (MAX_LINE_COUNT)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_comp0    (s_comp0),
        .s_comp1    (s_comp1),
        .s_comp2    (s_comp2),
        .s_comp3    (s_comp3),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out0     (m_out0),
        .m_out1     (m_out1),
        .m_out2     (m_out2),
        .m_out3     (m_out3),
        .m_frame_end(m_frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic mbd_pkg::pixel_t px(input logic [COMP_W-1:0] c0, c1, c2, c3);
        return {c3, c2, c1, c0};
    endfunction

    // mostly uniform, with the component extremes mixed in
    function automatic mbd_pkg::pixel_t rand_pixel();
        mbd_pkg::pixel_t p;
        int              r;
        for (int k = 0; k < mbd_pkg::NCOMP; k++) begin
            r = $urandom_range(9);
            if (r == 0)
                p[k] = '0;
            else if (r == 1)
                p[k] = '1;
            else
                p[k] = COMP_W'($urandom_range(255));
        end
        return p;
    endfunction

    task automatic send_pixel(input mbd_pkg::pixel_t p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_comp0 <= p[0];
        s_comp1 <= p[1];
        s_comp2 <= p[2];
        s_comp3 <= p[3];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (last) begin
            cfg_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic set_dims(input logic [CFG_DATA_W-1:0] len, input logic [CFG_DATA_W-1:0] cnt,
                            input bit spare_write);
        write_reg(mbd_pkg::REG_LINE_LENGTH, len, 1'b0);
        if (spare_write)
            write_reg($urandom_range(1) ? REG_SPARE : REG_UNUSED, CFG_DATA_W'($urandom), 1'b0);
        write_reg(mbd_pkg::REG_LINE_COUNT, cnt, 1'b1);
    endtask

    // stop sending and let the pipeline drain before touching the registers
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic run_random(input int budget);
        int sent;
        int len;
        int cnt;
        int area;
        int n;
        sent = 0;
        area = 1;
        while (sent < budget) begin
            wait_idle();
            if (sent > 0 && $urandom_range(9) == 0) begin
                // unused index: frame position must carry on
                write_reg($urandom_range(1) ? REG_SPARE : REG_UNUSED,
                          CFG_DATA_W'($urandom), 1'b1);
            end else begin
                len  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
                cnt  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                area = ((len == 0) ? 1 : len) * ((cnt == 0) ? 1 : cnt);
                set_dims(CFG_DATA_W'(len), CFG_DATA_W'(cnt), $urandom_range(3) == 0);
            end
            n = area * $urandom_range(1, 2);
            if ($urandom_range(2) == 0)
                n += $urandom_range(area);
            repeat (n) send_pixel(rand_pixel());
            sent += n;
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_comp0      = '0;
        s_comp1      = '0;
        s_comp2      = '0;
        s_comp3      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = mbd_pkg::REG_LINE_LENGTH;
        cfg_data     = '0;
        src_idle_pct = 36;
        snk_idle_pct = 48;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // two lines and two more pixels at the dimensions left by reset
        repeat (130) send_pixel(rand_pixel());

        wait_idle();
        set_dims(11'd2, 11'd2, 1'b0);
        repeat (4) send_pixel(px(8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(px(8'd1, 8'd2, 8'd3, 8'd255));
        send_pixel(px(8'd0, 8'd0, 8'd0, 8'd255));
        send_pixel(px(8'd0, 8'd1, 8'd0, 8'd255));
        send_pixel(px(8'd0, 8'd0, 8'd0, 8'd254));

        // a register write in mid-frame restarts the frame
        repeat (3) send_pixel(px(8'd255, 8'd255, 8'd255, 8'd255));
        wait_idle();
        set_dims(11'd2, 11'd2, 1'b1);
        repeat (4) send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0));

        wait_idle();
        set_dims(11'd0, 11'd2047, 1'b0);
        repeat (2) send_pixel(rand_pixel());

        wait_idle();
        set_dims(11'd3, 11'd3, 1'b0);
        repeat (9) send_pixel(rand_pixel());

        run_random(RANDOM_ITEMS);
        src_idle_pct = 48;
        snk_idle_pct = 36;
        run_random(RANDOM_ITEMS);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(RANDOM_ITEMS);

        wait_idle();
        set_dims(11'd2047, 11'd2, 1'b0);
        repeat (8) send_pixel(rand_pixel());
        wait_idle();
        set_dims(11'd4, 11'd2047, 1'b0);
        repeat (24) send_pixel(rand_pixel());

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- mipmap_box_downsample_top.f -----
rtl/mbd_pkg.sv
rtl/mbd_ram.sv
rtl/mbd_cfg.sv
rtl/mbd_ctrl.sv
rtl/mbd_filter.sv
rtl/mipmap_box_downsample_top.sv
bench/box_avg_checker.sv
bench/tb_top.sv
